@@ src/session_time_accumulator_table_macros.svh @@
// Assertion helpers; clock and reset are taken from the enclosing module.
`ifndef SESSION_TIME_ACCUMULATOR_TABLE_MACROS_SVH
`define SESSION_TIME_ACCUMULATOR_TABLE_MACROS_SVH

// Same-cycle implication.
`define STAT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define STAT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/stat_pkg.sv @@
`timescale 1ns / 1ps

package stat_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 1024;
   localparam int NAME_BYTES_DEFAULT  = 32;

   localparam int WORD_W        = 64;
   localparam int TIME_W        = 32;
   localparam int TOTAL_W       = 48;
   localparam int TYPE_W        = 8;
   localparam int FUNC_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_INDEX_W = 10;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 8;

   localparam logic [FUNC_W-1:0] FUNC_LOG   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STS_UPDATED   = 3'd0;
   localparam logic [STATUS_W-1:0] STS_IGNORED   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STS_CLOSED    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOGIN  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOGOUT = 1'd1;

   localparam logic [TYPE_W-1:0] LOGIN_CODE_RESET  = 8'd7;
   localparam logic [TYPE_W-1:0] LOGOUT_CODE_RESET = 8'd8;

   typedef struct packed {
      logic load;
      logic walk;
      logic close_mode;
      logic act;
   } stat_cmd_type;

   typedef struct packed {
      logic hit;
      logic walk_done;
      logic rsp_busy;
   } stat_sts_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [TIME_W-1:0]  login;
      logic               open;
   } stat_entry_type;

endpackage

@@ src/stat_req_if.sv @@
`timescale 1ns / 1ps

interface stat_req_if;
   import stat_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [TYPE_W-1:0]   record_type;
   logic [WORD_W-1:0]   name_word0;
   logic [WORD_W-1:0]   name_word1;
   logic [WORD_W-1:0]   name_word2;
   logic [WORD_W-1:0]   name_word3;
   logic [TIME_W-1:0]   event_time;

   modport source (
      output valid, func, record_type, name_word0, name_word1, name_word2, name_word3,
             event_time,
      input  ready
   );

   modport sink (
      input  valid, func, record_type, name_word0, name_word1, name_word2, name_word3,
             event_time,
      output ready
   );
endinterface

@@ src/stat_rsp_if.sv @@
`timescale 1ns / 1ps

interface stat_rsp_if;
   import stat_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic [ENTRY_INDEX_W-1:0]    entry_index;
   logic signed [TOTAL_W-1:0]   total_seconds;
   logic                        session_open;

   modport source (
      output valid, status, entry_index, total_seconds, session_open,
      input  ready
   );

   modport sink (
      input  valid, status, entry_index, total_seconds, session_open,
      output ready
   );
endinterface

@@ src/session_time_accumulator_table.sv @@
`timescale 1ns / 1ps
// Session time table, one entry per name.
// req_chan carries one request: a log record (login or logout by type code),
// a close of all open sessions, or a lookup of a name's total. rsp_chan
// returns exactly one result per request. csr_we/csr_index/csr_data set the
// login and logout type codes; write them only while the block is idle.
// A request that names an entry scans the name memory one entry per cycle
// through its single read port until the name is found or the used entries
// are exhausted. Close-all walks every used entry the same way; a reserved
// function code goes to the result with no scan. One request is worked on at
// a time: the next one transfers only once the result has been loaded and the
// block is back in idle. Reset empties the table and restores login code 7
// and logout code 8; it needs no clearing pass. The result sits in an output
// register: while rsp_chan is stalled the next request is still taken and
// worked on, and its result waits until the register is free.
module session_time_accumulator_table #(
   parameter int MAX_ENTRIES = stat_pkg::MAX_ENTRIES_DEFAULT,
   parameter int NAME_BYTES  = stat_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   stat_req_if.sink                         req_chan,
   stat_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [stat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [stat_pkg::CSR_DATA_W-1:0]  csr_data
);
   import stat_pkg::*;

   stat_cmd_type        cmd;
   stat_sts_type        sts;
   logic                req_ready;
   logic [TOTAL_W-1:0]  rsp_total;

   stat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stat_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_func          (req_chan.func),
      .req_record_type   (req_chan.record_type),
      .req_name_word0    (req_chan.name_word0),
      .req_name_word1    (req_chan.name_word1),
      .req_name_word2    (req_chan.name_word2),
      .req_name_word3    (req_chan.name_word3),
      .req_event_time    (req_chan.event_time),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_entry_index   (rsp_chan.entry_index),
      .rsp_total_seconds (rsp_total),
      .rsp_session_open  (rsp_chan.session_open)
   );

   assign req_chan.ready         = req_ready;
   assign rsp_chan.total_seconds = $signed(rsp_total);

endmodule

@@ src/stat_ctrl.sv @@
`timescale 1ns / 1ps
`include "session_time_accumulator_table_macros.svh"

module stat_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [stat_pkg::FUNC_W-1:0] req_func,
   output logic                        req_ready,
   input  stat_pkg::stat_sts_type      sts,
   output stat_pkg::stat_cmd_type      cmd
);
   import stat_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_CLOSE = 2'd2;
   localparam logic [1:0] S_ACT   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_fire;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               unique case (req_func)
                  FUNC_LOG, FUNC_QUERY: state_in = S_SCAN;
                  FUNC_CLOSE:           state_in = S_CLOSE;
                  default:              state_in = S_ACT;
               endcase
            end
         end
         S_SCAN: begin
            cmd.walk = 1'b1;
            if (sts.hit || sts.walk_done) state_in = S_ACT;
         end
         S_CLOSE: begin
            cmd.walk       = 1'b1;
            cmd.close_mode = 1'b1;
            if (sts.walk_done) state_in = S_ACT;
         end
         S_ACT: begin
            if (!sts.rsp_busy) begin
               cmd.act  = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `STAT_ASSERT_NXT(a_fire_leaves_idle, req_fire, state_ff != S_IDLE)
   `STAT_ASSERT_IMP(a_act_needs_slot, cmd.act, !sts.rsp_busy)
   `STAT_ASSERT_IMP(a_load_alone, cmd.load, !cmd.walk && !cmd.act)

endmodule

@@ src/stat_dp.sv @@
`timescale 1ns / 1ps
`include "session_time_accumulator_table_macros.svh"

module stat_dp #(
   parameter int MAX_ENTRIES = stat_pkg::MAX_ENTRIES_DEFAULT,
   parameter int NAME_BYTES  = stat_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [stat_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stat_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [stat_pkg::FUNC_W-1:0]        req_func,
   input  logic [stat_pkg::TYPE_W-1:0]        req_record_type,
   input  logic [stat_pkg::WORD_W-1:0]        req_name_word0,
   input  logic [stat_pkg::WORD_W-1:0]        req_name_word1,
   input  logic [stat_pkg::WORD_W-1:0]        req_name_word2,
   input  logic [stat_pkg::WORD_W-1:0]        req_name_word3,
   input  logic [stat_pkg::TIME_W-1:0]        req_event_time,
   input  stat_pkg::stat_cmd_type             cmd,
   output stat_pkg::stat_sts_type             sts,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [stat_pkg::STATUS_W-1:0]      rsp_status,
   output logic [stat_pkg::ENTRY_INDEX_W-1:0] rsp_entry_index,
   output logic [stat_pkg::TOTAL_W-1:0]       rsp_total_seconds,
   output logic                               rsp_session_open
);
   import stat_pkg::*;

   localparam int KEY_W = 8 * NAME_BYTES;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   function automatic logic [TOTAL_W-1:0] sat_add(
      input logic [TOTAL_W-1:0] total,
      input logic [TIME_W-1:0]  t,
      input logic [TIME_W-1:0]  login
   );
      logic [TIME_W:0]  diff;
      logic [TOTAL_W:0] sum;
      diff = {1'b0, t} - {1'b0, login};
      sum  = {total[TOTAL_W-1], total} + {{(TOTAL_W - TIME_W){diff[TIME_W]}}, diff};
      if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
         return sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
      end
      return sum[TOTAL_W-1:0];
   endfunction

   // key forming: keep bytes up to the first zero byte
   logic [4*WORD_W-1:0]   name_raw;
   logic [NAME_BYTES-1:0] byte_nz;
   logic [NAME_BYTES-1:0] byte_alive;
   logic [KEY_W-1:0]      key_in;

   assign name_raw = {req_name_word3, req_name_word2, req_name_word1, req_name_word0};

   for (genvar k = 0; k < NAME_BYTES; k++) begin : g_key
      assign byte_nz[k]         = |name_raw[8*k +: 8];
      assign byte_alive[k]      = &byte_nz[k:0];
      assign key_in[8*k +: 8]   = byte_alive[k] ? name_raw[8*k +: 8] : 8'h00;
   end

   logic [TYPE_W-1:0]    login_code_ff;
   logic [TYPE_W-1:0]    logout_code_ff;

   logic [FUNC_W-1:0]    func_ff;
   logic [TYPE_W-1:0]    rtype_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [TIME_W-1:0]    time_ff;

   logic [CNT_W-1:0]     used_ff;
   logic [CNT_W-1:0]     scan_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [KEY_W-1:0]     name_rd_ff;
   stat_entry_type       ent_rd_ff;
   logic                 hit_ff;

   logic [KEY_W-1:0]     name_mem [MAX_ENTRIES];
   stat_entry_type       ent_mem  [MAX_ENTRIES];

   logic                 issue_ok;
   logic                 hit_now;
   logic                 rd_en;
   logic [TOTAL_W-1:0]   sum_total;
   logic                 close_wb;

   logic                 act_name_we;
   logic                 act_ent_we;
   logic                 act_used_inc;
   logic [IDX_W-1:0]     act_wr_idx;
   stat_entry_type       act_ent;
   logic [STATUS_W-1:0]  act_status;
   logic [IDX_W-1:0]     act_idx;
   logic [TOTAL_W-1:0]   act_total;
   logic                 act_open;
   logic                 act_entry;
   logic                 is_login;
   logic                 is_logout;
   logic                 full;

   logic                 ent_we;
   logic [IDX_W-1:0]     ent_wr_idx;
   stat_entry_type       ent_wr_data;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;
   logic                 rsp_open_ff;

   assign issue_ok  = scan_ff < used_ff;
   assign hit_now   = cmd.walk && !cmd.close_mode && rd_vld_ff && (name_rd_ff == key_ff);
   assign rd_en     = cmd.walk && issue_ok && !hit_now;
   assign sum_total = sat_add(ent_rd_ff.total, time_ff, ent_rd_ff.login);
   assign close_wb  = cmd.walk && cmd.close_mode && rd_vld_ff && ent_rd_ff.open;

   assign sts.hit       = hit_now;
   assign sts.walk_done = !issue_ok && !rd_vld_ff;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      is_login     = (rtype_ff == login_code_ff);
      is_logout    = (rtype_ff == logout_code_ff);
      full         = (used_ff == CNT_W'(MAX_ENTRIES));
      act_name_we  = 1'b0;
      act_ent_we   = 1'b0;
      act_used_inc = 1'b0;
      act_wr_idx   = rd_idx_ff;
      act_ent      = ent_rd_ff;
      act_status   = STS_IGNORED;
      act_idx      = rd_idx_ff;
      act_total    = ent_rd_ff.total;
      act_open     = ent_rd_ff.open;
      act_entry    = 1'b0;
      unique case (func_ff)
         FUNC_CLOSE: begin
            act_status = STS_CLOSED;
         end
         FUNC_QUERY: begin
            act_status = hit_ff ? STS_UPDATED : STS_NOT_FOUND;
            act_entry  = hit_ff;
         end
         FUNC_LOG: begin
            priority if (is_login) begin
               priority if (hit_ff) begin
                  act_ent_we     = 1'b1;
                  act_ent.login  = time_ff;
                  act_ent.open   = 1'b1;
                  act_status     = STS_UPDATED;
                  act_open       = 1'b1;
                  act_entry      = 1'b1;
               end else if (full) begin
                  act_status = STS_FULL;
               end else begin
                  act_name_we   = 1'b1;
                  act_ent_we    = 1'b1;
                  act_used_inc  = 1'b1;
                  act_wr_idx    = used_ff[IDX_W-1:0];
                  act_ent.total = '0;
                  act_ent.login = time_ff;
                  act_ent.open  = 1'b1;
                  act_status    = STS_UPDATED;
                  act_idx       = used_ff[IDX_W-1:0];
                  act_total     = '0;
                  act_open      = 1'b1;
                  act_entry     = 1'b1;
               end
            end else if (is_logout) begin
               priority if (!hit_ff) begin
                  act_status = STS_NOT_FOUND;
               end else if (!ent_rd_ff.open) begin
                  act_status = STS_IGNORED;
                  act_entry  = 1'b1;
               end else begin
                  act_ent_we    = 1'b1;
                  act_ent.total = sum_total;
                  act_ent.open  = 1'b0;
                  act_status    = STS_UPDATED;
                  act_total     = sum_total;
                  act_open      = 1'b0;
                  act_entry     = 1'b1;
               end
            end else begin
               act_status = STS_IGNORED;
            end
         end
         default: begin
            act_status = STS_IGNORED;
         end
      endcase
   end

   always_comb begin
      ent_we      = close_wb || (cmd.act && act_ent_we);
      ent_wr_idx  = act_wr_idx;
      ent_wr_data = act_ent;
      if (close_wb) begin
         ent_wr_idx  = rd_idx_ff;
         ent_wr_data = '{total: sum_total, login: ent_rd_ff.login, open: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act && act_name_we) name_mem[act_wr_idx] <= key_ff;
      if (rd_en) name_rd_ff <= name_mem[scan_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wr_idx] <= ent_wr_data;
      if (rd_en) ent_rd_ff <= ent_mem[scan_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         rtype_ff <= req_record_type;
         key_ff   <= key_in;
         time_ff  <= req_event_time;
      end
      if (rd_en) rd_idx_ff <= scan_ff[IDX_W-1:0];
      if (cmd.act) begin
         rsp_status_ff <= act_status;
         rsp_idx_ff    <= act_entry ? act_idx : '0;
         rsp_total_ff  <= act_entry ? act_total : '0;
         rsp_open_ff   <= act_entry && act_open;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         login_code_ff  <= LOGIN_CODE_RESET;
         logout_code_ff <= LOGOUT_CODE_RESET;
         used_ff        <= '0;
         scan_ff        <= '0;
         rd_vld_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOGIN:  login_code_ff  <= csr_data[TYPE_W-1:0];
               CSR_LOGOUT: logout_code_ff <= csr_data[TYPE_W-1:0];
            endcase
         end
         if (cmd.act && act_used_inc) used_ff <= used_ff + CNT_W'(1);
         if (cmd.load) begin
            scan_ff <= '0;
         end else if (rd_en) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         rd_vld_ff <= rd_en;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (hit_now) begin
            hit_ff <= 1'b1;
         end
         if (cmd.act) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = ENTRY_INDEX_W'(rsp_idx_ff);
   assign rsp_total_seconds = rsp_total_ff;
   assign rsp_session_open  = rsp_open_ff;

   `STAT_ASSERT_IMP(a_used_bound, 1'b1, used_ff <= CNT_W'(MAX_ENTRIES))
   `STAT_ASSERT_IMP(a_hit_in_range, hit_now, CNT_W'(rd_idx_ff) < used_ff)
   `STAT_ASSERT_NXT(a_act_shows_result, cmd.act, rsp_valid_ff)

endmodule

@@ bench/tb_session_time_accumulator_table.sv @@
`timescale 1ns / 1ps

module tb_session_time_accumulator_table;
   import stat_pkg::*;

   localparam int TABLE_SIZE = MAX_ENTRIES_DEFAULT;
   localparam int NAME_W = 4 * WORD_W;
   localparam int POOL_SIZE = 24;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
   localparam longint TOTAL_HI = 64'h7FFF_FFFF_FFFF;
   localparam longint TOTAL_LO = -TOTAL_HI - 1;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [TYPE_W-1:0] record_type;
      logic [NAME_W-1:0] name;
      logic [TIME_W-1:0] event_time;
   } log_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [ENTRY_INDEX_W-1:0]  entry_index;
      logic signed [TOTAL_W-1:0] total_seconds;
      logic                      session_open;
   } log_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   stat_req_if req_if();
   stat_rsp_if rsp_if();

   session_time_accumulator_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   logic [NAME_W-1:0]         key_tab   [TABLE_SIZE];
   logic signed [TOTAL_W-1:0] total_tab [TABLE_SIZE];
   logic [TIME_W-1:0]         login_tab [TABLE_SIZE];
   bit                        open_tab  [TABLE_SIZE];
   int                        used_count;
   logic [TYPE_W-1:0]         login_code;
   logic [TYPE_W-1:0]         logout_code;

   log_req_type       pending_reqs[$];
   log_rsp_type       expected_rsps[$];
   logic [NAME_W-1:0] pool_name[POOL_SIZE];
   int                pool_len[POOL_SIZE];
   logic [TIME_W-1:0] run_clock;
   int                gap_left;
   int                stall_left;
   int                fail_count;
   bit                quiet;

   function automatic logic [NAME_W-1:0] name_key(logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] key;
      bit ended;
      key = '0;
      ended = 1'b0;
      for (int b = 0; b < NAME_W / 8; b++) begin
         if (b >= NAME_BYTES_DEFAULT || raw[8*b +: 8] == 8'h00) ended = 1'b1;
         if (!ended) key[8*b +: 8] = raw[8*b +: 8];
      end
      return key;
   endfunction

   function automatic int find_entry(logic [NAME_W-1:0] key);
      for (int i = 0; i < used_count; i++)
         if (key_tab[i] == key) return i;
      return -1;
   endfunction

   function automatic void close_session(int i, logic [TIME_W-1:0] t);
      longint sum;
      if (!open_tab[i]) return;
      sum = longint'(total_tab[i]) + (longint'({32'd0, t}) - longint'({32'd0, login_tab[i]}));
      if (sum > TOTAL_HI) sum = TOTAL_HI;
      if (sum < TOTAL_LO) sum = TOTAL_LO;
      total_tab[i] = sum[TOTAL_W-1:0];
      open_tab[i] = 1'b0;
   endfunction

   function automatic log_rsp_type entry_rsp(logic [STATUS_W-1:0] status, int i);
      log_rsp_type r;
      r = '0;
      r.status = status;
      if (i >= 0) begin
         r.entry_index = i[ENTRY_INDEX_W-1:0];
         r.total_seconds = total_tab[i];
         r.session_open = open_tab[i];
      end
      return r;
   endfunction

   function automatic log_rsp_type account_request(log_req_type q);
      logic [NAME_W-1:0] key;
      int i;
      case (q.func)
         FUNC_CLOSE: begin
            for (int k = 0; k < used_count; k++) close_session(k, q.event_time);
            return entry_rsp(STS_CLOSED, -1);
         end
         FUNC_RESERVED: return entry_rsp(STS_IGNORED, -1);
         default: ;
      endcase
      key = name_key(q.name);
      i = find_entry(key);
      if (q.func == FUNC_QUERY) return entry_rsp(i < 0 ? STS_NOT_FOUND : STS_UPDATED, i);
      if (q.record_type == login_code) begin
         if (i < 0) begin
            if (used_count >= TABLE_SIZE) return entry_rsp(STS_FULL, -1);
            i = used_count;
            used_count++;
            key_tab[i] = key;
            total_tab[i] = '0;
         end
         login_tab[i] = q.event_time;
         open_tab[i] = 1'b1;
         return entry_rsp(STS_UPDATED, i);
      end
      if (q.record_type == logout_code) begin
         if (i < 0) return entry_rsp(STS_NOT_FOUND, -1);
         if (!open_tab[i]) return entry_rsp(STS_IGNORED, i);
         close_session(i, q.event_time);
         return entry_rsp(STS_UPDATED, i);
      end
      return entry_rsp(STS_IGNORED, -1);
   endfunction

   function automatic logic [NAME_W-1:0] text_name(string s);
      logic [NAME_W-1:0] n;
      n = '0;
      for (int b = 0; b < s.len() && b < NAME_W / 8; b++) n[8*b +: 8] = s[b];
      return n;
   endfunction

   function automatic logic [NAME_W-1:0] random_name(int len);
      logic [NAME_W-1:0] n;
      n = '0;
      for (int b = 0; b < len; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
      return n;
   endfunction

   function automatic logic [NAME_W-1:0] pick_name();
      logic [NAME_W-1:0] n;
      int p;
      if ($urandom_range(0, 9) == 0) return random_name($urandom_range(0, NAME_W / 8));
      p = $urandom_range(0, POOL_SIZE - 1);
      n = pool_name[p];
      // garbage past the terminator must not change the key
      if (pool_len[p] < NAME_W / 8 - 1 && $urandom_range(0, 3) == 0)
         for (int b = pool_len[p] + 1; b < NAME_W / 8; b++) n[8*b +: 8] = 8'($urandom);
      return n;
   endfunction

   task automatic post_request(logic [FUNC_W-1:0] f, logic [TYPE_W-1:0] rt,
                               logic [NAME_W-1:0] n, logic [TIME_W-1:0] t);
      log_req_type q;
      q.func = f;
      q.record_type = rt;
      q.name = n;
      q.event_time = t;
      pending_reqs.push_back(q);
   endtask

   task automatic queue_random_item();
      int pick;
      logic [TIME_W-1:0] t;
      logic [NAME_W-1:0] n;
      pick = $urandom_range(0, 99);
      n = pick_name();
      run_clock += $urandom_range(0, 5000);
      t = ($urandom_range(0, 9) == 0) ? $urandom : run_clock;
      if (pick < 42) post_request(FUNC_LOG, login_code, n, t);
      else if (pick < 80) post_request(FUNC_LOG, logout_code, n, t);
      else if (pick < 86) post_request(FUNC_LOG, 8'($urandom), n, t);
      else if (pick < 90) post_request(FUNC_CLOSE, 8'($urandom), n, t);
      else if (pick < 97) post_request(FUNC_QUERY, 8'($urandom), n, t);
      else post_request(FUNC_RESERVED, 8'($urandom), n, t);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LOGIN) login_code = val;
      else logout_code = val;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      log_req_type q;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            q.func = req_if.func;
            q.record_type = req_if.record_type;
            q.name = {req_if.name_word3, req_if.name_word2, req_if.name_word1,
                      req_if.name_word0};
            q.event_time = req_if.event_time;
            expected_rsps.push_back(account_request(q));
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 6);
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               q = pending_reqs.pop_front();
               req_if.valid <= 1'b1;
               req_if.func <= q.func;
               req_if.record_type <= q.record_type;
               req_if.name_word0 <= q.name[0*WORD_W +: WORD_W];
               req_if.name_word1 <= q.name[1*WORD_W +: WORD_W];
               req_if.name_word2 <= q.name[2*WORD_W +: WORD_W];
               req_if.name_word3 <= q.name[3*WORD_W +: WORD_W];
               req_if.event_time <= q.event_time;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      log_rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result transfer with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                  fail_count++;
               end
               if (rsp_if.entry_index !== want.entry_index) begin
                  $error("entry_index: expected %0d, actual %0d", want.entry_index,
                         rsp_if.entry_index);
                  fail_count++;
               end
               if (rsp_if.total_seconds !== want.total_seconds) begin
                  $error("total_seconds: expected %0d, actual %0d", want.total_seconds,
                         rsp_if.total_seconds);
                  fail_count++;
               end
               if (rsp_if.session_open !== want.session_open) begin
                  $error("session_open: expected %0d, actual %0d", want.session_open,
                         rsp_if.session_open);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [NAME_W-1:0] alice;
      logic [NAME_W-1:0] bob;
      logic [NAME_W-1:0] full_name;
      logic [NAME_W-1:0] split_name;
      logic [NAME_W-1:0] fill_name;
      logic [NAME_W-1:0] spare_name;
      logic [TYPE_W-1:0] code_a;
      logic [TYPE_W-1:0] code_b;
      int needed;
      int serial;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      quiet = 1'b0;
      fail_count = 0;
      used_count = 0;
      login_code = LOGIN_CODE_RESET;
      logout_code = LOGOUT_CODE_RESET;
      run_clock = 32'd1000;
      req_if.valid = 1'b0;
      req_if.func = '0;
      req_if.record_type = '0;
      req_if.name_word0 = '0;
      req_if.name_word1 = '0;
      req_if.name_word2 = '0;
      req_if.name_word3 = '0;
      req_if.event_time = '0;
      rsp_if.ready = 1'b0;

      alice = text_name("alice");
      bob = text_name("bob");
      full_name = '1;
      split_name = text_name("ab") | (text_name("cd") << 24) | {8'hFF, {(NAME_W-8){1'b0}}};
      spare_name = text_name("overflow-user");
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_len[p] = (p < 4) ? NAME_W / 8 : $urandom_range(1, 12);
         pool_name[p] = random_name(pool_len[p]);
      end

      post_request(FUNC_LOG, LOGIN_CODE_RESET, alice, 32'd100);
      post_request(FUNC_QUERY, 8'd0, alice, 32'd0);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, alice, 32'd250);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, alice, 32'd300);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, bob, 32'd10);
      post_request(FUNC_QUERY, 8'hFF, bob, 32'd0);
      post_request(FUNC_LOG, 8'h00, alice, 32'd400);
      post_request(FUNC_LOG, 8'hFF, alice, 32'd500);
      post_request(FUNC_RESERVED, LOGIN_CODE_RESET, alice, 32'd600);
      post_request(FUNC_LOG, LOGIN_CODE_RESET, '0, 32'd0);
      post_request(FUNC_LOG, LOGIN_CODE_RESET, full_name, 32'hFFFF_FFFF);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, full_name, 32'd0);
      post_request(FUNC_LOG, LOGIN_CODE_RESET, split_name, 32'd5);
      post_request(FUNC_QUERY, 8'd0, text_name("ab"), 32'd0);
      post_request(FUNC_LOG, LOGIN_CODE_RESET, text_name("ab"), 32'd20);
      post_request(FUNC_LOG, LOGIN_CODE_RESET, alice, 32'd1000);
      post_request(FUNC_CLOSE, 8'd0, '0, 32'hFFFF_FFFF);
      post_request(FUNC_QUERY, 8'd0, alice, 32'd0);
      post_request(FUNC_QUERY, 8'd0, '0, 32'd0);
      post_request(FUNC_CLOSE, 8'hFF, full_name, 32'd0);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, '0, 32'd7);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               code_a = LOGIN_CODE_RESET;
               code_b = LOGOUT_CODE_RESET;
            end
            1: begin
               code_a = 8'h00;
               code_b = 8'hFF;
            end
            2: begin
               code_a = 8'hFF;
               code_b = 8'h00;
            end
            3: begin
               code_a = 8'($urandom);
               code_b = code_a;
            end
            default: begin
               code_a = 8'($urandom);
               code_b = 8'($urandom);
            end
         endcase
         write_reg(CSR_LOGIN, code_a);
         write_reg(CSR_LOGOUT, code_b);
         @(negedge clock);
         repeat (100) queue_random_item();
         drain();
      end

      write_reg(CSR_LOGIN, LOGIN_CODE_RESET);
      write_reg(CSR_LOGOUT, LOGOUT_CODE_RESET);
      @(negedge clock);
      quiet = 1'b1;
      needed = TABLE_SIZE - used_count;
      serial = 0;
      fill_name = '0;
      while (needed > 0) begin
         fill_name = '0;
         fill_name[7:0] = 8'h7E;
         fill_name[15:8] = {1'b1, serial[6:0]};
         fill_name[23:16] = {1'b1, serial[13:7]};
         serial++;
         if (find_entry(name_key(fill_name)) < 0) begin
            run_clock += 32'd3;
            post_request(FUNC_LOG, LOGIN_CODE_RESET, fill_name, run_clock);
            needed--;
         end
      end
      post_request(FUNC_LOG, LOGIN_CODE_RESET, spare_name, run_clock);
      post_request(FUNC_LOG, LOGIN_CODE_RESET, alice, 32'd50);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, alice, 32'd90);
      post_request(FUNC_LOG, LOGOUT_CODE_RESET, spare_name, 32'd90);
      post_request(FUNC_QUERY, 8'd0, fill_name, 32'd0);
      post_request(FUNC_CLOSE, 8'd0, '0, run_clock + 32'd10_000);
      post_request(FUNC_QUERY, 8'd0, fill_name, 32'd0);
      post_request(FUNC_QUERY, 8'd0, spare_name, 32'd0);
      drain();

      repeat (1100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_session_time_accumulator_table: clean");
      end else begin
         $display("tb_session_time_accumulator_table: errors");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("tb_session_time_accumulator_table: errors");
      $finish;
   end

endmodule
